// ----- rtl/ecn_header_remark_assert.svh -----
// Assertion macros for the ECN header remark block.
`ifndef ECN_HEADER_REMARK_ASSERT_SVH
`define ECN_HEADER_REMARK_ASSERT_SVH

// Condition in the same cycle implies consequence.
`define ECNHR_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("ecn_header_remark same-cycle check failed");

// Condition implies consequence in the next cycle.
`define ECNHR_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("ecn_header_remark next-cycle check failed");

`endif

// ----- rtl/ecnhr_pkg.sv -----
// Package: types, register indexes and checksum patch function for ECN remark.
`timescale 1ns / 1ps

package ecnhr_pkg;

    localparam int CSUM_W    = 16;
    localparam int TOS_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 2;
    localparam int ECE_BIT   = 6;
    localparam int CWR_BIT   = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_IP_ECN   = 3'd0,
        CFG_IP_ECN_VALUE = 3'd1,
        CFG_SET_ECE      = 3'd2,
        CFG_ECE_VALUE    = 3'd3,
        CFG_SET_CWR      = 3'd4,
        CFG_CWR_VALUE    = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [TOS_W-1:0]  ip_tos;
        logic [CSUM_W-1:0] ip_header_checksum;
        logic              is_tcp;
        logic              tcp_header_complete;
        logic [CSUM_W-1:0] tcp_flags_word;
        logic [CSUM_W-1:0] tcp_checksum;
        logic              checksum_offloaded;
    } hdr_in_t;

    typedef struct packed {
        logic              verdict;
        logic [TOS_W-1:0]  new_tos;
        logic [CSUM_W-1:0] new_ip_checksum;
        logic [CSUM_W-1:0] new_tcp_flags_word;
        logic [CSUM_W-1:0] new_tcp_checksum;
        logic              full_checksum_needed;
    } hdr_out_t;

    function automatic logic [CSUM_W-1:0] csum_patch(
        input logic [CSUM_W-1:0] hc,
        input logic [CSUM_W-1:0] oldw,
        input logic [CSUM_W-1:0] neww
    );
        logic [CSUM_W+1:0] sum;
        logic [CSUM_W:0]   fold1;
        logic [CSUM_W:0]   fold2;
        sum   = {2'b00, ~hc} + {2'b00, ~oldw} + {2'b00, neww};
        fold1 = {1'b0, sum[CSUM_W-1:0]} + {{(CSUM_W-1){1'b0}}, sum[CSUM_W+1:CSUM_W]};
        fold2 = {1'b0, fold1[CSUM_W-1:0]} + {{CSUM_W{1'b0}}, fold1[CSUM_W]};
        return ~fold2[CSUM_W-1:0];
    endfunction

endpackage

// ----- rtl/ecn_header_remark.sv -----
// ECN header remark: rewrites IP ECN and TCP ECE/CWR with incremental checksums.
//
// Usage: one packet header per input beat (in_valid / in_stall), one result
// beat per header (out_valid / out_stall). A beat moves on a rising edge with
// valid high and stall low. The six configuration registers are written
// through cfg_write / cfg_index / cfg_data while no header is in flight.
// Pipeline: input register, then result register. Throughput: one header per
// cycle while out_stall is low; the checksum patch is a single 3-input add
// with two end-around folds between the two registers.
// Reset: rst_n low clears both stage valids and all configuration registers
// (all rewrites disabled).
// Stall: when out_stall holds a result, the input stage still takes one more
// beat; in_stall rises only when both stages hold beats that cannot advance.
// Headers are never dropped or duplicated; verdict reports truncated TCP when ECE or CWR rewrite is on.
`timescale 1ns / 1ps

`include "ecn_header_remark_assert.svh"

module ecn_header_remark
    import ecnhr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [TOS_W-1:0]     ip_tos,
    input  logic [CSUM_W-1:0]    ip_header_checksum,
    input  logic                 is_tcp,
    input  logic                 tcp_header_complete,
    input  logic [CSUM_W-1:0]    tcp_flags_word,
    input  logic [CSUM_W-1:0]    tcp_checksum,
    input  logic                 checksum_offloaded,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 verdict,
    output logic [TOS_W-1:0]     new_tos,
    output logic [CSUM_W-1:0]    new_ip_checksum,
    output logic [CSUM_W-1:0]    new_tcp_flags_word,
    output logic [CSUM_W-1:0]    new_tcp_checksum,
    output logic                 full_checksum_needed
);

    logic       set_ip_ecn_reg;
    logic [1:0] ip_ecn_value_reg;
    logic       set_ece_reg;
    logic       ece_value_reg;
    logic       set_cwr_reg;
    logic       cwr_value_reg;

    logic     s1_valid_reg;
    hdr_in_t  s1_reg;
    logic     out_valid_reg;
    hdr_out_t out_reg;
    hdr_out_t out_next;

    logic out_adv;
    logic s1_adv;
    logic in_fire;

    logic              ip_change;
    logic [TOS_W-1:0]  tos_mod;
    logic              tcp_path;
    logic              ece_diff;
    logic              cwr_diff;
    logic              tcp_change;
    logic [CSUM_W-1:0] flags_mod;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_ip_ecn_reg   <= 1'b0;
            ip_ecn_value_reg <= 2'b00;
            set_ece_reg      <= 1'b0;
            ece_value_reg    <= 1'b0;
            set_cwr_reg      <= 1'b0;
            cwr_value_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SET_IP_ECN:   set_ip_ecn_reg   <= cfg_data[0];
                CFG_IP_ECN_VALUE: ip_ecn_value_reg <= cfg_data[1:0];
                CFG_SET_ECE:      set_ece_reg      <= cfg_data[0];
                CFG_ECE_VALUE:    ece_value_reg    <= cfg_data[0];
                CFG_SET_CWR:      set_cwr_reg      <= cfg_data[0];
                CFG_CWR_VALUE:    cwr_value_reg    <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Handshake: advance each stage when the next one is free.
    assign out_adv  = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_adv;
    assign in_stall = s1_valid_reg && !out_adv;
    assign in_fire  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_reg.ip_tos              <= ip_tos;
            s1_reg.ip_header_checksum  <= ip_header_checksum;
            s1_reg.is_tcp              <= is_tcp;
            s1_reg.tcp_header_complete <= tcp_header_complete;
            s1_reg.tcp_flags_word      <= tcp_flags_word;
            s1_reg.tcp_checksum        <= tcp_checksum;
            s1_reg.checksum_offloaded  <= checksum_offloaded;
        end
        if (s1_adv)
        begin
            out_reg <= out_next;
        end
    end

    // Rewrite and checksum patch.
    always_comb
    begin
        ip_change = set_ip_ecn_reg && (s1_reg.ip_tos[1:0] != ip_ecn_value_reg);
        tos_mod   = {s1_reg.ip_tos[TOS_W-1:2], ip_ecn_value_reg};

        tcp_path = (set_ece_reg || set_cwr_reg) && s1_reg.is_tcp;
        ece_diff = set_ece_reg && (s1_reg.tcp_flags_word[ECE_BIT] != ece_value_reg);
        cwr_diff = set_cwr_reg && (s1_reg.tcp_flags_word[CWR_BIT] != cwr_value_reg);
        tcp_change = tcp_path && s1_reg.tcp_header_complete && (ece_diff || cwr_diff);

        flags_mod = s1_reg.tcp_flags_word;
        if (set_ece_reg)
        begin
            flags_mod[ECE_BIT] = ece_value_reg;
        end
        if (set_cwr_reg)
        begin
            flags_mod[CWR_BIT] = cwr_value_reg;
        end

        out_next.verdict = tcp_path && !s1_reg.tcp_header_complete;
        out_next.new_tos = ip_change ? tos_mod : s1_reg.ip_tos;
        out_next.new_ip_checksum = ip_change
            ? csum_patch(s1_reg.ip_header_checksum,
                         {{(CSUM_W-TOS_W){1'b0}}, s1_reg.ip_tos},
                         {{(CSUM_W-TOS_W){1'b0}}, tos_mod})
            : s1_reg.ip_header_checksum;
        out_next.new_tcp_flags_word = tcp_change ? flags_mod : s1_reg.tcp_flags_word;
        out_next.new_tcp_checksum = (tcp_change && !s1_reg.checksum_offloaded)
            ? csum_patch(s1_reg.tcp_checksum, s1_reg.tcp_flags_word, flags_mod)
            : s1_reg.tcp_checksum;
        out_next.full_checksum_needed = tcp_change && s1_reg.checksum_offloaded;
    end

    assign out_valid            = out_valid_reg;
    assign verdict              = out_reg.verdict;
    assign new_tos              = out_reg.new_tos;
    assign new_ip_checksum      = out_reg.new_ip_checksum;
    assign new_tcp_flags_word   = out_reg.new_tcp_flags_word;
    assign new_tcp_checksum     = out_reg.new_tcp_checksum;
    assign full_checksum_needed = out_reg.full_checksum_needed;

    `ECNHR_ASSERT_SAME(a_full_not_drop, clk, rst_n,
        out_valid_reg && out_reg.full_checksum_needed, !out_reg.verdict)
    `ECNHR_ASSERT_SAME(a_stall_needs_beat, clk, rst_n, in_stall,
        s1_valid_reg && out_valid_reg)
    `ECNHR_ASSERT_NEXT(a_held_beat_kept, clk, rst_n, s1_valid_reg && !s1_adv,
        s1_valid_reg)

endmodule
